### rtl/interrupt_priority_controller_core_assert.svh
// Assertion macros for the interrupt priority controller RTL.
// No dependencies; included by ipc_seq, the only module that carries assertions.
`ifndef INTERRUPT_PRIORITY_CONTROLLER_CORE_ASSERT_SVH
`define INTERRUPT_PRIORITY_CONTROLLER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define IPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipc assertion failed");

// Consequent checked in the cycle after the antecedent.
`define IPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipc assertion failed");

`endif

### rtl/ipc_pkg.sv
// Shared types, codes, writable-bit tables and source ROM for the
// interrupt priority controller. No dependencies.
package ipc_pkg;

    localparam int NUM_SOURCES_DEF   = 60;
    localparam int NUM_PRIO_REGS_DEF = 12;
    localparam int NUM_MASK_REGS_DEF = 13;
    localparam int ROM_ENTRIES       = 60;

    localparam logic [15:0] NMI_CTRL_RST = 16'h00c0;

    // access modes
    localparam logic [2:0] MODE_PRIO_WR = 3'd0;
    localparam logic [2:0] MODE_MASK_SET = 3'd1;
    localparam logic [2:0] MODE_MASK_CLR = 3'd2;
    localparam logic [2:0] MODE_PRIO_RD = 3'd3;
    localparam logic [2:0] MODE_MASK_RD = 3'd4;
    localparam logic [2:0] MODE_STATUS  = 3'd5;

    // config register indexes
    localparam logic [1:0] CFG_LEVEL    = 2'd0;
    localparam logic [1:0] CFG_IRQ_PRIO = 2'd1;
    localparam logic [1:0] CFG_IRQ_MASK = 2'd2;
    localparam logic [1:0] CFG_NMI_CTRL = 2'd3;

    // ROM priority-source and mask-source codes
    localparam logic [4:0] PR_IRQWORD = 5'd12;
    localparam logic [4:0] PR_FIXED   = 5'd16;
    localparam logic [3:0] MR_IRQBYTE = 4'd13;
    localparam logic [3:0] MR_NMI     = 4'd14;
    localparam logic [3:0] MR_NONE    = 4'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [4:0]  pr;
        logic [4:0]  pos;
        logic [3:0]  mr;
        logic [7:0]  msk;
        logic [11:0] evt;
    } t_rom_entry;

    typedef struct packed {
        logic ready;
        logic access;
        logic scan;
        logic load;
    } t_seq_ctl;

    typedef struct packed {
        logic       eligible;
        logic [3:0] prio;
    } t_cand;

    typedef struct packed {
        logic       found;
        logic [5:0] src;
        logic [3:0] prio;
    } t_best;

    typedef struct packed {
        logic        we_prio;
        logic        set_mask;
        logic        clr_mask;
        logic [3:0]  idx;
        logic [15:0] value;
    } t_access;

    function automatic logic [15:0] prio_writable(input logic [3:0] idx);
        logic [15:0] w;
        unique case (idx)
            4'd0, 4'd1, 4'd6: w = 16'hfff0;
            4'd2:             w = 16'h000f;
            4'd3:             w = 16'h0f00;
            4'd4, 4'd8:       w = 16'hf0f0;
            4'd5, 4'd7, 4'd9: w = 16'hffff;
            4'd10, 4'd11:     w = 16'hff00;
            default:          w = 16'h0000;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] mask_writable(input logic [3:0] idx);
        logic [7:0] w;
        unique case (idx)
            4'd0, 4'd2, 4'd8: w = 8'h07;
            4'd1:             w = 8'h0f;
            4'd3:             w = 8'hfc;
            4'd4:             w = 8'h79;
            4'd5:             w = 8'hf7;
            4'd6:             w = 8'h1b;
            4'd7:             w = 8'hff;
            4'd9:             w = 8'h12;
            4'd10:            w = 8'h37;
            4'd11:            w = 8'h01;
            4'd12:            w = 8'h38;
            default:          w = 8'h00;
        endcase
        return w;
    endfunction

    // Source table: priority location, mask location, event code.
    // Fixed priorities are encoded as PR_FIXED + level.
    function automatic t_rom_entry rom_entry(input logic [5:0] s);
        t_rom_entry e;
        unique case (s)
            6'd0:  e = '{5'd31, 5'd0, MR_NMI, 8'h40, 12'h1c0};
            6'd1:  e = '{5'd30, 5'd0, MR_NONE, 8'h00, 12'h5e0};
            6'd2:  e = '{PR_IRQWORD, 5'd28, MR_IRQBYTE, 8'h80, 12'h600};
            6'd3:  e = '{PR_IRQWORD, 5'd24, MR_IRQBYTE, 8'h40, 12'h620};
            6'd4:  e = '{PR_IRQWORD, 5'd20, MR_IRQBYTE, 8'h20, 12'h640};
            6'd5:  e = '{PR_IRQWORD, 5'd16, MR_IRQBYTE, 8'h10, 12'h660};
            6'd6:  e = '{5'd1, 5'd4, 4'd3, 8'h10, 12'h700};
            6'd7:  e = '{5'd1, 5'd4, 4'd3, 8'h20, 12'h720};
            6'd8:  e = '{5'd1, 5'd4, 4'd3, 8'h40, 12'h740};
            6'd9:  e = '{5'd1, 5'd4, 4'd3, 8'h80, 12'h760};
            6'd10: e = '{5'd4, 5'd12, 4'd1, 8'h01, 12'h800};
            6'd11: e = '{5'd4, 5'd12, 4'd1, 8'h02, 12'h820};
            6'd12: e = '{5'd4, 5'd12, 4'd1, 8'h04, 12'h840};
            6'd13: e = '{5'd4, 5'd12, 4'd1, 8'h08, 12'h860};
            6'd14: e = '{5'd4, 5'd4, 4'd2, 8'h01, 12'h900};
            6'd15: e = '{5'd9, 5'd12, 4'd6, 8'h08, 12'h9e0};
            6'd16: e = '{5'd5, 5'd4, 4'd9, 8'h02, 12'ha20};
            6'd17: e = '{5'd10, 5'd12, 4'd10, 8'h01, 12'ha80};
            6'd18: e = '{5'd10, 5'd12, 4'd10, 8'h02, 12'haa0};
            6'd19: e = '{5'd10, 5'd12, 4'd10, 8'h04, 12'hac0};
            6'd20: e = '{5'd10, 5'd8, 4'd10, 8'h10, 12'hb00};
            6'd21: e = '{5'd10, 5'd8, 4'd10, 8'h20, 12'hb20};
            6'd22: e = '{5'd5, 5'd8, 4'd5, 8'h10, 12'hb80};
            6'd23: e = '{5'd5, 5'd8, 4'd5, 8'h20, 12'hba0};
            6'd24: e = '{5'd5, 5'd8, 4'd5, 8'h40, 12'hbc0};
            6'd25: e = '{5'd5, 5'd12, 4'd5, 8'h80, 12'hbe0};
            6'd26: e = '{5'd6, 5'd12, 4'd5, 8'h01, 12'hc00};
            6'd27: e = '{5'd6, 5'd8, 4'd5, 8'h02, 12'hc20};
            6'd28: e = '{5'd6, 5'd4, 4'd5, 8'h04, 12'hc40};
            6'd29: e = '{5'd7, 5'd12, 4'd6, 8'h01, 12'hc80};
            6'd30: e = '{5'd7, 5'd8, 4'd6, 8'h02, 12'hca0};
            6'd31: e = '{5'd8, 5'd12, 4'd6, 8'h10, 12'hd00};
            6'd32: e = '{5'd7, 5'd4, 4'd7, 8'h04, 12'hd80};
            6'd33: e = '{5'd7, 5'd4, 4'd7, 8'h08, 12'hda0};
            6'd34: e = '{5'd7, 5'd4, 4'd7, 8'h01, 12'hdc0};
            6'd35: e = '{5'd7, 5'd4, 4'd7, 8'h02, 12'hde0};
            6'd36: e = '{5'd7, 5'd0, 4'd7, 8'h10, 12'he00};
            6'd37: e = '{5'd7, 5'd0, 4'd7, 8'h20, 12'he20};
            6'd38: e = '{5'd7, 5'd0, 4'd7, 8'h40, 12'he40};
            6'd39: e = '{5'd7, 5'd0, 4'd7, 8'h80, 12'he60};
            6'd40: e = '{5'd5, 5'd0, 4'd9, 8'h10, 12'hf00};
            6'd41: e = '{5'd8, 5'd4, 4'd11, 8'h01, 12'hf20};
            6'd42: e = '{5'd1, 5'd8, 4'd4, 8'h01, 12'hf40};
            6'd43: e = '{5'd9, 5'd4, 4'd8, 8'h01, 12'hf80};
            6'd44: e = '{5'd11, 5'd12, 4'd8, 8'h02, 12'hfa0};
            6'd45: e = '{5'd11, 5'd8, 4'd8, 8'h04, 12'hfc0};
            6'd46: e = '{5'd0, 5'd12, 4'd4, 8'h10, 12'h400};
            6'd47: e = '{5'd0, 5'd8, 4'd4, 8'h20, 12'h420};
            6'd48: e = '{5'd0, 5'd4, 4'd4, 8'h40, 12'h440};
            6'd49: e = '{5'd9, 5'd0, 4'd0, 8'h02, 12'h4e0};
            6'd50: e = '{5'd9, 5'd0, 4'd0, 8'h04, 12'h500};
            6'd51: e = '{5'd9, 5'd0, 4'd0, 8'h01, 12'h520};
            6'd52: e = '{5'd1, 5'd12, 4'd4, 8'h08, 12'h560};
            6'd53: e = '{5'd3, 5'd8, 4'd12, 8'h08, 12'h580};
            6'd54: e = '{5'd3, 5'd8, 4'd12, 8'h10, 12'h5a0};
            6'd55: e = '{5'd3, 5'd8, 4'd12, 8'h20, 12'h5c0};
            6'd56: e = '{5'd2, 5'd0, 4'd3, 8'h04, 12'hcc0};
            6'd57: e = '{5'd2, 5'd0, 4'd3, 8'h08, 12'hce0};
            6'd58: e = '{5'd9, 5'd8, 4'd2, 8'h02, 12'hd40};
            6'd59: e = '{5'd9, 5'd8, 4'd2, 8'h04, 12'hd60};
            default: e = '{5'd0, 5'd0, MR_NONE, 8'h00, 12'h000};
        endcase
        return e;
    endfunction

endpackage

### rtl/ipc_regs.sv
// Priority and mask register banks with one read port each.
// Depends on ipc_pkg.
module ipc_regs #(
    parameter int NUM_PRIO_REGS = ipc_pkg::NUM_PRIO_REGS_DEF,
    parameter int NUM_MASK_REGS = ipc_pkg::NUM_MASK_REGS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ipc_pkg::t_access i_acc,
    input  logic [3:0]       i_prio_addr,
    input  logic [3:0]       i_mask_addr,
    output logic [15:0]      o_prio_rdata,
    output logic [7:0]       o_mask_rdata
);
    import ipc_pkg::*;

    localparam int PAW = (NUM_PRIO_REGS > 1) ? $clog2(NUM_PRIO_REGS) : 1;
    localparam int MAW = (NUM_MASK_REGS > 1) ? $clog2(NUM_MASK_REGS) : 1;

    logic [15:0] r_prio [NUM_PRIO_REGS];
    logic [7:0]  r_mask [NUM_MASK_REGS];
    logic [7:0]  wbits;
    logic [7:0]  n_mask;

    assign o_prio_rdata = (5'(i_prio_addr) < 5'(NUM_PRIO_REGS))
                        ? r_prio[i_prio_addr[PAW-1:0]] : 16'h0000;
    assign o_mask_rdata = (5'(i_mask_addr) < 5'(NUM_MASK_REGS))
                        ? r_mask[i_mask_addr[MAW-1:0]] : 8'h00;

    // set/clear is read-modify-write: caller points the mask port at idx
    assign wbits  = i_acc.value[7:0] & mask_writable(i_acc.idx);
    assign n_mask = i_acc.set_mask ? (o_mask_rdata | wbits) : (o_mask_rdata & ~wbits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PRIO_REGS; i++) r_prio[i] <= 16'h0000;
            for (int i = 0; i < NUM_MASK_REGS; i++) r_mask[i] <= 8'h00;
        end else begin
            if (i_acc.we_prio) begin
                r_prio[i_acc.idx[PAW-1:0]] <= i_acc.value & prio_writable(i_acc.idx);
            end
            if (i_acc.set_mask || i_acc.clr_mask) begin
                r_mask[i_acc.idx[MAW-1:0]] <= n_mask;
            end
        end
    end

endmodule

### rtl/ipc_seq.sv
// Scan sequencer: access step, one-source-per-cycle scan through a shared
// priority comparator, result hand-off. Depends on ipc_pkg and assert macros.
`include "interrupt_priority_controller_core_assert.svh"

module ipc_seq #(
    parameter int NUM_SOURCES = ipc_pkg::NUM_SOURCES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_out_free,
    input  ipc_pkg::t_cand    i_cand,
    input  logic [3:0]        i_level,
    output ipc_pkg::t_seq_ctl o_ctl,
    output logic [5:0]        o_src,
    output ipc_pkg::t_best    o_best
);
    import ipc_pkg::*;

    localparam int         SCAN_LEN = (NUM_SOURCES < ROM_ENTRIES) ? NUM_SOURCES : ROM_ENTRIES;
    localparam logic [5:0] SRC_LAST = 6'(SCAN_LEN - 1);

    t_state     r_state, n_state;
    logic [5:0] r_src, n_src;
    logic [3:0] r_level, n_level;
    t_best      r_best, n_best;
    logic       best_hit;
    logic       scan_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_src   <= 6'd0;
            r_level <= 4'd0;
            r_best  <= '0;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_level <= n_level;
            r_best  <= n_best;
        end
    end

    always_comb begin
        n_state = r_state;
        n_src   = r_src;
        n_level = r_level;
        n_best  = r_best;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.ready = 1'b1;
                if (i_start) begin
                    n_state = ST_ACCESS;
                    n_level = i_level;
                end
            end
            ST_ACCESS: begin
                o_ctl.access = 1'b1;
                n_state      = ST_SCAN;
                n_src        = 6'd0;
                n_best       = '{found: 1'b0, src: 6'd0, prio: r_level};
            end
            ST_SCAN: begin
                o_ctl.scan = 1'b1;
                // strict compare: ties keep the lower source number
                if (i_cand.eligible && (i_cand.prio > r_best.prio)) begin
                    n_best = '{found: 1'b1, src: r_src, prio: i_cand.prio};
                end
                if (r_src == SRC_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_src = r_src + 6'd1;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
        endcase
    end

    assign o_src  = r_src;
    assign o_best = r_best;

    assign best_hit  = (r_state == ST_SCAN || r_state == ST_DONE) && r_best.found;
    assign scan_last = (r_state == ST_SCAN) && (r_src == SRC_LAST);

    `IPC_ASSERT_NOW(a_best_above_level, i_clk, i_rst_n, best_hit, r_best.prio > r_level)
    `IPC_ASSERT_NOW(a_src_in_range, i_clk, i_rst_n, (r_state == ST_SCAN), (r_src <= SRC_LAST))
    `IPC_ASSERT_NEXT(a_start_access, i_clk, i_rst_n, o_ctl.ready && i_start, r_state == ST_ACCESS)
    `IPC_ASSERT_NEXT(a_scan_end, i_clk, i_rst_n, scan_last, (r_state == ST_DONE))

endmodule

### rtl/interrupt_priority_controller_core.sv
// Interrupt priority controller core: one access, then a rescan of all sources.
// After a word is taken the block runs the access step, then a scan that feeds one
// source per cycle through the single priority comparator; no new word is taken
// until the result has been handed to the output register.
// Reset (i_rst_n low, synchronous): priority, mask and config registers 0, nmi_control
// 0x00c0, no source raised, output empty; the block is ready the cycle after reset.
module interrupt_priority_controller_core #(
    parameter int NUM_SOURCES   = ipc_pkg::NUM_SOURCES_DEF,
    parameter int NUM_PRIO_REGS = ipc_pkg::NUM_PRIO_REGS_DEF,
    parameter int NUM_MASK_REGS = ipc_pkg::NUM_MASK_REGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // access words in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] mode, [8:3] index, [24:9] value, [25] raised, [31:26] zero
    input  logic [31:0] s_axis_tdata,
    // result words out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] read_data, [16] pending_valid, [22:17] pending_source,
    // [34:23] event_code, [38:35] pending_priority, [39] zero
    output logic [39:0] m_axis_tdata
);
    import ipc_pkg::*;

    localparam int SIW = $clog2(NUM_SOURCES);

    // config registers
    logic [3:0]  r_level;
    logic [31:0] r_irq_prio;
    logic [7:0]  r_irq_mask;
    logic [15:0] r_nmi_ctrl;

    // captured access word
    logic [2:0]  r_mode;
    logic [5:0]  r_index;
    logic [15:0] r_value;
    logic        r_raised_in;

    logic [NUM_SOURCES-1:0] r_raised;

    // output stage
    logic        r_out_valid;
    logic [15:0] r_rd_data;
    logic [15:0] r_out_rd;
    logic        r_out_found;
    logic [5:0]  r_out_src;
    logic [11:0] r_out_evt;
    logic [3:0]  r_out_prio;

    t_seq_ctl   ctl;
    t_best      best;
    t_cand      cand;
    t_access    acc;
    t_rom_entry ent;
    t_rom_entry win_ent;
    logic [5:0] scan_src;
    logic [3:0] prio_addr, mask_addr;
    logic [15:0] prio_rdata;
    logic [7:0]  mask_rdata;
    logic        prio_ok, mask_ok, src_ok;
    logic        out_free;
    logic        accept;
    logic        masked;
    logic [15:0] rd_next;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign prio_ok = r_index < 6'(NUM_PRIO_REGS);
    assign mask_ok = r_index < 6'(NUM_MASK_REGS);
    assign src_ok  = 7'(r_index) < 7'(NUM_SOURCES);

    ipc_seq #(
        .NUM_SOURCES(NUM_SOURCES)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (s_axis_tvalid),
        .i_out_free(out_free),
        .i_cand    (cand),
        .i_level   (r_level),
        .o_ctl     (ctl),
        .o_src     (scan_src),
        .o_best    (best)
    );

    assign s_axis_tready = ctl.ready;

    // Read ports: the access step uses the word's index, the scan uses the
    // register numbers from the current source's ROM entry.
    assign ent       = rom_entry(scan_src);
    assign prio_addr = ctl.scan ? ent.pr[3:0] : r_index[3:0];
    assign mask_addr = ctl.scan ? ent.mr : r_index[3:0];

    always_comb begin
        acc          = '0;
        acc.idx      = r_index[3:0];
        acc.value    = r_value;
        acc.we_prio  = ctl.access && (r_mode == MODE_PRIO_WR) && prio_ok;
        acc.set_mask = ctl.access && (r_mode == MODE_MASK_SET) && mask_ok;
        acc.clr_mask = ctl.access && (r_mode == MODE_MASK_CLR) && mask_ok;
    end

    ipc_regs #(
        .NUM_PRIO_REGS(NUM_PRIO_REGS),
        .NUM_MASK_REGS(NUM_MASK_REGS)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_prio_addr (prio_addr),
        .i_mask_addr (mask_addr),
        .o_prio_rdata(prio_rdata),
        .o_mask_rdata(mask_rdata)
    );

    // Candidate decode for the source under scan. Missing registers read 0,
    // so a priority from one is 0 and a mask bit in one is clear.
    always_comb begin
        cand = '0;
        priority if (ent.pr < PR_IRQWORD) begin
            cand.prio = 4'(prio_rdata >> ent.pos);
        end else if (ent.pr == PR_IRQWORD) begin
            cand.prio = 4'(r_irq_prio >> ent.pos);
        end else if (ent.pr >= PR_FIXED) begin
            cand.prio = ent.pr[3:0];
        end else begin
            cand.prio = 4'd0;
        end

        priority if (ent.mr < MR_IRQBYTE) begin
            masked = |(mask_rdata & ent.msk);
        end else if (ent.mr == MR_IRQBYTE) begin
            masked = |(r_irq_mask & ent.msk);
        end else if (ent.mr == MR_NMI) begin
            masked = |(r_nmi_ctrl[15:8] & ent.msk);
        end else begin
            masked = 1'b0;
        end

        cand.eligible = r_raised[scan_src[SIW-1:0]] && !masked;
    end

    // read data for register reads, zero otherwise
    always_comb begin
        rd_next = 16'h0000;
        if (r_mode == MODE_PRIO_RD && prio_ok) begin
            rd_next = prio_rdata;
        end else if (r_mode == MODE_MASK_RD && mask_ok) begin
            rd_next = {8'h00, mask_rdata};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= 4'd0;
            r_irq_prio <= 32'd0;
            r_irq_mask <= 8'd0;
            r_nmi_ctrl <= NMI_CTRL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_LEVEL:    r_level    <= i_cfg_wdata[3:0];
                CFG_IRQ_PRIO: r_irq_prio <= i_cfg_wdata;
                CFG_IRQ_MASK: r_irq_mask <= i_cfg_wdata[7:0];
                CFG_NMI_CTRL: r_nmi_ctrl <= i_cfg_wdata[15:0];
            endcase
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode      <= s_axis_tdata[2:0];
            r_index     <= s_axis_tdata[8:3];
            r_value     <= s_axis_tdata[24:9];
            r_raised_in <= s_axis_tdata[25];
        end
        if (ctl.access) begin
            r_rd_data <= rd_next;
        end
    end

    // source raised status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raised <= '0;
        end else if (ctl.access && (r_mode == MODE_STATUS) && src_ok) begin
            r_raised[r_index[SIW-1:0]] <= r_raised_in;
        end
    end

    // output register: a finished word waits here while the next access starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // table entry of the winner, for its event code
    assign win_ent = rom_entry(best.src);

    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_out_rd    <= r_rd_data;
            r_out_found <= best.found;
            r_out_src   <= best.found ? best.src : 6'd0;
            r_out_evt   <= best.found ? win_ent.evt : 12'd0;
            r_out_prio  <= best.found ? best.prio : 4'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_prio, r_out_evt, r_out_src, r_out_found, r_out_rd};

endmodule

### sim/interrupt_priority_controller_core_checker.sv
// Scoreboard for the interrupt priority controller core: tracks config writes and
// access words, models the post-access rescan and checks every result word.
// Depends on ipc_pkg for mode, config and table location codes.
module interrupt_priority_controller_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    output int          o_fail_count,
    output int          o_outstanding
);
    import ipc_pkg::*;

    // where a source gets its priority and mask bit, plus its event code
    typedef struct packed {
        logic [4:0]  pr;
        logic [4:0]  pos;
        logic [3:0]  mr;
        logic [7:0]  mbit;
        logic [11:0] evt;
    } t_route;

    // result word layout, msb first
    typedef struct packed {
        logic        pad;
        logic [3:0]  prio;
        logic [11:0] evt;
        logic [5:0]  src;
        logic        hit;
        logic [15:0] rd;
    } t_offer;

    t_route      rt [0:NUM_SOURCES_DEF-1];
    logic [15:0] prio_wr_bits [0:15];
    logic [7:0]  mask_wr_bits [0:15];

    logic [3:0]  lvl;
    logic [31:0] irq_prio;
    logic [7:0]  irq_mask;
    logic [15:0] nmi_ctl;
    logic [15:0] prio_reg [0:15];
    logic [7:0]  mask_reg [0:15];
    logic        raised_src [0:63];

    t_offer predicted_offers [$];
    int     mismatches = 0;

    function automatic t_route route(input logic [4:0] pr, input logic [4:0] pos,
                                     input logic [3:0] mr, input logic [7:0] mbit,
                                     input logic [11:0] evt);
        t_route r;
        r.pr   = pr;
        r.pos  = pos;
        r.mr   = mr;
        r.mbit = mbit;
        r.evt  = evt;
        return r;
    endfunction

    initial begin : tables
        int k;
        for (k = 0; k < 16; k++) begin
            prio_wr_bits[k] = 16'h0000;
            mask_wr_bits[k] = 8'h00;
        end
        prio_wr_bits[0]  = 16'hfff0;  prio_wr_bits[1]  = 16'hfff0;
        prio_wr_bits[2]  = 16'h000f;  prio_wr_bits[3]  = 16'h0f00;
        prio_wr_bits[4]  = 16'hf0f0;  prio_wr_bits[5]  = 16'hffff;
        prio_wr_bits[6]  = 16'hfff0;  prio_wr_bits[7]  = 16'hffff;
        prio_wr_bits[8]  = 16'hf0f0;  prio_wr_bits[9]  = 16'hffff;
        prio_wr_bits[10] = 16'hff00;  prio_wr_bits[11] = 16'hff00;
        mask_wr_bits[0]  = 8'h07;  mask_wr_bits[1]  = 8'h0f;  mask_wr_bits[2]  = 8'h07;
        mask_wr_bits[3]  = 8'hfc;  mask_wr_bits[4]  = 8'h79;  mask_wr_bits[5]  = 8'hf7;
        mask_wr_bits[6]  = 8'h1b;  mask_wr_bits[7]  = 8'hff;  mask_wr_bits[8]  = 8'h07;
        mask_wr_bits[9]  = 8'h12;  mask_wr_bits[10] = 8'h37;  mask_wr_bits[11] = 8'h01;
        mask_wr_bits[12] = 8'h38;

        // 0: NMI, fixed level 15; 1: fixed level 14, never masked
        rt[0]  = route(PR_FIXED + 5'd15, 5'd0, MR_NMI, 8'h40, 12'h1c0);
        rt[1]  = route(PR_FIXED + 5'd14, 5'd0, MR_NONE, 8'h00, 12'h5e0);
        rt[2]  = route(PR_IRQWORD, 5'd28, MR_IRQBYTE, 8'h80, 12'h600);
        rt[3]  = route(PR_IRQWORD, 5'd24, MR_IRQBYTE, 8'h40, 12'h620);
        rt[4]  = route(PR_IRQWORD, 5'd20, MR_IRQBYTE, 8'h20, 12'h640);
        rt[5]  = route(PR_IRQWORD, 5'd16, MR_IRQBYTE, 8'h10, 12'h660);
        rt[6]  = route(5'd1, 5'd4, 4'd3, 8'h10, 12'h700);
        rt[7]  = route(5'd1, 5'd4, 4'd3, 8'h20, 12'h720);
        rt[8]  = route(5'd1, 5'd4, 4'd3, 8'h40, 12'h740);
        rt[9]  = route(5'd1, 5'd4, 4'd3, 8'h80, 12'h760);
        rt[10] = route(5'd4, 5'd12, 4'd1, 8'h01, 12'h800);
        rt[11] = route(5'd4, 5'd12, 4'd1, 8'h02, 12'h820);
        rt[12] = route(5'd4, 5'd12, 4'd1, 8'h04, 12'h840);
        rt[13] = route(5'd4, 5'd12, 4'd1, 8'h08, 12'h860);
        rt[14] = route(5'd4, 5'd4, 4'd2, 8'h01, 12'h900);
        rt[15] = route(5'd9, 5'd12, 4'd6, 8'h08, 12'h9e0);
        rt[16] = route(5'd5, 5'd4, 4'd9, 8'h02, 12'ha20);
        rt[17] = route(5'd10, 5'd12, 4'd10, 8'h01, 12'ha80);
        rt[18] = route(5'd10, 5'd12, 4'd10, 8'h02, 12'haa0);
        rt[19] = route(5'd10, 5'd12, 4'd10, 8'h04, 12'hac0);
        rt[20] = route(5'd10, 5'd8, 4'd10, 8'h10, 12'hb00);
        rt[21] = route(5'd10, 5'd8, 4'd10, 8'h20, 12'hb20);
        rt[22] = route(5'd5, 5'd8, 4'd5, 8'h10, 12'hb80);
        rt[23] = route(5'd5, 5'd8, 4'd5, 8'h20, 12'hba0);
        rt[24] = route(5'd5, 5'd8, 4'd5, 8'h40, 12'hbc0);
        rt[25] = route(5'd5, 5'd12, 4'd5, 8'h80, 12'hbe0);
        rt[26] = route(5'd6, 5'd12, 4'd5, 8'h01, 12'hc00);
        rt[27] = route(5'd6, 5'd8, 4'd5, 8'h02, 12'hc20);
        rt[28] = route(5'd6, 5'd4, 4'd5, 8'h04, 12'hc40);
        rt[29] = route(5'd7, 5'd12, 4'd6, 8'h01, 12'hc80);
        rt[30] = route(5'd7, 5'd8, 4'd6, 8'h02, 12'hca0);
        rt[31] = route(5'd8, 5'd12, 4'd6, 8'h10, 12'hd00);
        rt[32] = route(5'd7, 5'd4, 4'd7, 8'h04, 12'hd80);
        rt[33] = route(5'd7, 5'd4, 4'd7, 8'h08, 12'hda0);
        rt[34] = route(5'd7, 5'd4, 4'd7, 8'h01, 12'hdc0);
        rt[35] = route(5'd7, 5'd4, 4'd7, 8'h02, 12'hde0);
        rt[36] = route(5'd7, 5'd0, 4'd7, 8'h10, 12'he00);
        rt[37] = route(5'd7, 5'd0, 4'd7, 8'h20, 12'he20);
        rt[38] = route(5'd7, 5'd0, 4'd7, 8'h40, 12'he40);
        rt[39] = route(5'd7, 5'd0, 4'd7, 8'h80, 12'he60);
        rt[40] = route(5'd5, 5'd0, 4'd9, 8'h10, 12'hf00);
        rt[41] = route(5'd8, 5'd4, 4'd11, 8'h01, 12'hf20);
        rt[42] = route(5'd1, 5'd8, 4'd4, 8'h01, 12'hf40);
        rt[43] = route(5'd9, 5'd4, 4'd8, 8'h01, 12'hf80);
        rt[44] = route(5'd11, 5'd12, 4'd8, 8'h02, 12'hfa0);
        rt[45] = route(5'd11, 5'd8, 4'd8, 8'h04, 12'hfc0);
        rt[46] = route(5'd0, 5'd12, 4'd4, 8'h10, 12'h400);
        rt[47] = route(5'd0, 5'd8, 4'd4, 8'h20, 12'h420);
        rt[48] = route(5'd0, 5'd4, 4'd4, 8'h40, 12'h440);
        rt[49] = route(5'd9, 5'd0, 4'd0, 8'h02, 12'h4e0);
        rt[50] = route(5'd9, 5'd0, 4'd0, 8'h04, 12'h500);
        rt[51] = route(5'd9, 5'd0, 4'd0, 8'h01, 12'h520);
        rt[52] = route(5'd1, 5'd12, 4'd4, 8'h08, 12'h560);
        rt[53] = route(5'd3, 5'd8, 4'd12, 8'h08, 12'h580);
        rt[54] = route(5'd3, 5'd8, 4'd12, 8'h10, 12'h5a0);
        rt[55] = route(5'd3, 5'd8, 4'd12, 8'h20, 12'h5c0);
        rt[56] = route(5'd2, 5'd0, 4'd3, 8'h04, 12'hcc0);
        rt[57] = route(5'd2, 5'd0, 4'd3, 8'h08, 12'hce0);
        rt[58] = route(5'd9, 5'd8, 4'd2, 8'h02, 12'hd40);
        rt[59] = route(5'd9, 5'd8, 4'd2, 8'h04, 12'hd60);
    end

    always @(posedge i_clk) begin : track
        int          k;
        int          idx;
        logic [2:0]  md;
        logic [15:0] val;
        logic [15:0] rd;
        logic [31:0] wide;
        logic [3:0]  p;
        logic        msk;
        t_route      r;
        t_offer      want;
        t_offer      got;

        if (!i_rst_n) begin
            lvl      = 4'd0;
            irq_prio = 32'd0;
            irq_mask = 8'd0;
            nmi_ctl  = NMI_CTRL_RST;
            for (k = 0; k < 16; k++) begin
                prio_reg[k] = 16'd0;
                mask_reg[k] = 8'd0;
            end
            for (k = 0; k < 64; k++) raised_src[k] = 1'b0;
            predicted_offers.delete();
        end else begin
            // result side first: a word never leaves in the cycle its access arrives
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (predicted_offers.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result word %h with nothing outstanding",
                                 $realtime, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = predicted_offers.pop_front();
                    if (got.rd !== want.rd || got.hit !== want.hit || got.src !== want.src ||
                        got.evt !== want.evt || got.prio !== want.prio ||
                        got.pad !== want.pad) begin
                        if (mismatches < 10) begin
                            $display("%0t: exp rd=%h hit=%b src=%0d evt=%h prio=%0d pad=%b",
                                     $realtime, want.rd, want.hit, want.src, want.evt,
                                     want.prio, want.pad);
                            $display("%0t: got rd=%h hit=%b src=%0d evt=%h prio=%0d pad=%b",
                                     $realtime, got.rd, got.hit, got.src, got.evt,
                                     got.prio, got.pad);
                        end
                        mismatches++;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_LEVEL:    lvl      = i_cfg_wdata[3:0];
                    CFG_IRQ_PRIO: irq_prio = i_cfg_wdata;
                    CFG_IRQ_MASK: irq_mask = i_cfg_wdata[7:0];
                    CFG_NMI_CTRL: nmi_ctl  = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) begin
                md  = s_axis_tdata[2:0];
                idx = int'(s_axis_tdata[8:3]);
                val = s_axis_tdata[24:9];
                rd  = 16'd0;
                case (md)
                    MODE_PRIO_WR:
                        if (idx < NUM_PRIO_REGS_DEF) prio_reg[idx] = val & prio_wr_bits[idx];
                    MODE_MASK_SET:
                        if (idx < NUM_MASK_REGS_DEF)
                            mask_reg[idx] = mask_reg[idx] | (val[7:0] & mask_wr_bits[idx]);
                    MODE_MASK_CLR:
                        if (idx < NUM_MASK_REGS_DEF)
                            mask_reg[idx] = mask_reg[idx] & ~(val[7:0] & mask_wr_bits[idx]);
                    MODE_PRIO_RD:
                        if (idx < NUM_PRIO_REGS_DEF) rd = prio_reg[idx];
                    MODE_MASK_RD:
                        if (idx < NUM_MASK_REGS_DEF) rd = {8'h00, mask_reg[idx]};
                    MODE_STATUS:
                        if (idx < NUM_SOURCES_DEF) raised_src[idx] = s_axis_tdata[25];
                    default: ;
                endcase

                // rescan: strictly greater keeps the lowest number on a tie,
                // and starting at the level drops everything at or below it
                want      = '0;
                want.rd   = rd;
                want.prio = lvl;
                for (k = 0; k < NUM_SOURCES_DEF; k++) begin
                    r = rt[k];
                    if (r.mr < MR_IRQBYTE)
                        msk = (r.mr < NUM_MASK_REGS_DEF) && ((mask_reg[r.mr] & r.mbit) != 0);
                    else if (r.mr == MR_IRQBYTE)
                        msk = (irq_mask & r.mbit) != 0;
                    else if (r.mr == MR_NMI)
                        msk = (nmi_ctl & {r.mbit, 8'h00}) != 0;
                    else
                        msk = 1'b0;
                    if (r.pr < PR_IRQWORD)
                        wide = (r.pr < NUM_PRIO_REGS_DEF) ? ({16'd0, prio_reg[r.pr]} >> r.pos)
                                                          : 32'd0;
                    else if (r.pr == PR_IRQWORD)
                        wide = irq_prio >> r.pos;
                    else if (r.pr >= PR_FIXED)
                        wide = {27'd0, 5'(r.pr - PR_FIXED)};
                    else
                        wide = 32'd0;
                    p = wide[3:0];
                    if (raised_src[k] && !msk && p > want.prio) begin
                        want.prio = p;
                        want.hit  = 1'b1;
                        want.src  = k[5:0];
                        want.evt  = r.evt;
                    end
                end
                if (!want.hit) want.prio = 4'd0;
                predicted_offers.push_back(want);
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= predicted_offers.size();
    end

endmodule

### sim/tb_interrupt_priority_controller_core.sv
// Testbench top for the interrupt priority controller core: reset, config phases,
// directed and random access words, random idling on both streams, verdict.
// Depends on ipc_pkg, the core and interrupt_priority_controller_core_checker.
module tb_interrupt_priority_controller_core;
    import ipc_pkg::*;

    // the two access modes that do nothing but rescan
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int MAX_IDLE     = 18;
    localparam int PHASES       = 8;
    localparam int WORDS_PHASE  = 50;
    // one scan plus the handshakes around it
    localparam int SCAN_CYCLES  = NUM_SOURCES_DEF + 3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_addr    = '0;
    logic [31:0] i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [2:0] mode, [8:3] index, [24:9] value, [25] raised, [31:26] zero
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] read_data, [16] pending_valid, [22:17] pending_source,
    // [34:23] event_code, [38:35] pending_priority, [39] zero
    logic [39:0] m_axis_tdata;

    // set for a whole phase: both streams run back to back
    logic no_idle = 1'b0;

    int fail_count;
    int outstanding;

    always #5 i_clk = ~i_clk;

    interrupt_priority_controller_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    interrupt_priority_controller_core_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Watchdog: the slowest run is roughly 450 words plus config phases,
    // and the timeout leaves a wide margin.
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    // All tasks are entered and left on a falling edge.

    // One access word. Gap before raising tvalid; sometimes the gap only
    // starts once the block shows ready, so idling also lands on the
    // cycles right after a scan ends.
    task automatic send_word(input logic [2:0] md, input logic [5:0] idx,
                             input logic [15:0] val, input logic rs);
        int   gap;
        logic hold;
        gap  = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        hold = !no_idle && ($urandom_range(0, 3) == 0);
        if (gap > 0 || hold) begin
            s_axis_tvalid <= 1'b0;
            if (hold) begin
                do @(negedge i_clk); while (!s_axis_tready);
            end
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {6'd0, rs, val, idx, md};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge i_clk);
    endtask

    // Drop tvalid and wait until every predicted word has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        @(negedge i_clk);
    endtask

    // One-cycle write pulse; the trailing cycle keeps back-to-back writes
    // from touching i_cfg_we twice in one step.
    task automatic cfg_write(input logic [1:0] addr, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_cfg();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_val();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly valid register numbers, now and then anything up to 63.
    function automatic logic [5:0] pick_reg();
        if ($urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, NUM_MASK_REGS_DEF - 1));
    endfunction

    // Result sink: random stall before taking a word, none in no_idle phases. Half of the
    // time the stall counts from the moment tvalid shows, so it really backs up.
    initial begin : result_sink
        int   stall;
        logic hold;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            hold  = !no_idle && ($urandom_range(0, 1) == 1);
            if (stall > 0 || hold) begin
                m_axis_tready <= 1'b0;
                if (hold) begin
                    do @(negedge i_clk); while (!m_axis_tvalid);
                end
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int          ph;
        int          n;
        int          pick;
        logic [2:0]  md;
        logic [5:0]  idx;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed, reset config ----
        send_word(MODE_PRIO_RD, 6'd0, 16'h0000, 1'b0);    // reset contents
        send_word(MODE_MASK_RD, 6'd0, 16'h0000, 1'b0);
        send_word(MODE_STATUS, 6'd1, 16'h0000, 1'b1);     // fixed level 14
        send_word(MODE_STATUS, 6'd0, 16'h0000, 1'b1);     // NMI outranks it
        send_word(MODE_PRIO_WR, 6'd0, 16'hffff, 1'b0);    // writable bits only
        send_word(MODE_PRIO_RD, 6'd0, 16'h0000, 1'b0);
        send_word(MODE_MASK_SET, 6'd0, 16'hffff, 1'b0);
        send_word(MODE_MASK_RD, 6'd0, 16'h0000, 1'b0);
        send_word(MODE_MASK_CLR, 6'd0, 16'hffff, 1'b0);
        // register numbers past the end: writes dropped, reads give zero
        send_word(MODE_PRIO_WR, 6'd63, 16'hffff, 1'b0);
        send_word(MODE_PRIO_RD, 6'd12, 16'h0000, 1'b0);
        send_word(MODE_MASK_SET, 6'd13, 16'hffff, 1'b0);
        send_word(MODE_MASK_RD, 6'd63, 16'h0000, 1'b0);
        // source numbers past the table are ignored
        send_word(MODE_STATUS, 6'd63, 16'hffff, 1'b1);
        send_word(MODE_STATUS, 6'd60, 16'h0000, 1'b1);
        send_word(MODE_SPARE_LO, 6'd63, 16'hffff, 1'b1);
        send_word(MODE_SPARE_HI, 6'd0, 16'h0000, 1'b0);
        send_word(MODE_STATUS, 6'd0, 16'h0000, 1'b0);     // drop both: no winner
        send_word(MODE_STATUS, 6'd1, 16'h0000, 1'b0);
        // tie between 10 and 11 at level 15: lower number wins
        send_word(MODE_PRIO_WR, 6'd4, 16'hf000, 1'b0);
        send_word(MODE_STATUS, 6'd11, 16'h0000, 1'b1);
        send_word(MODE_STATUS, 6'd10, 16'h0000, 1'b1);
        send_word(MODE_STATUS, 6'd14, 16'h0000, 1'b1);    // priority 0, never wins
        send_word(MODE_MASK_SET, 6'd1, 16'h0001, 1'b0);   // mask 10, 11 takes over
        drain();

        // ---- directed, config extremes ----
        cfg_write(CFG_LEVEL, 32'hffff_ffff);              // level 15 shuts out all
        send_word(MODE_STATUS, 6'd1, 16'h0000, 1'b1);
        drain();
        cfg_write(CFG_LEVEL, 32'h0000_0000);
        cfg_write(CFG_IRQ_PRIO, 32'hffff_ffff);
        cfg_write(CFG_IRQ_MASK, 32'hffff_ffff);
        cfg_write(CFG_NMI_CTRL, 32'hffff_ffff);           // NMI masked
        send_word(MODE_STATUS, 6'd0, 16'h0000, 1'b1);
        send_word(MODE_STATUS, 6'd2, 16'h0000, 1'b1);
        drain();
        cfg_write(CFG_IRQ_MASK, 32'h0000_0000);
        cfg_write(CFG_NMI_CTRL, 32'h0000_0000);
        send_word(MODE_STATUS, 6'd5, 16'h0000, 1'b1);
        drain();

        // ---- random phases, fresh config for each ----
        for (ph = 0; ph < PHASES; ph++) begin
            cfg_write(CFG_LEVEL, pick_cfg());
            cfg_write(CFG_IRQ_PRIO, pick_cfg());
            cfg_write(CFG_IRQ_MASK, pick_cfg());
            cfg_write(CFG_NMI_CTRL, pick_cfg());
            no_idle = (ph % 3 == 2);
            for (n = 0; n < WORDS_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                idx  = pick_reg();
                if (pick < 40) begin
                    md  = MODE_STATUS;
                    idx = ($urandom_range(0, 9) == 0)
                        ? 6'($urandom_range(NUM_SOURCES_DEF, 63))
                        : 6'($urandom_range(0, NUM_SOURCES_DEF - 1));
                end else if (pick < 55) begin
                    md = MODE_PRIO_WR;
                end else if (pick < 65) begin
                    md = MODE_MASK_SET;
                end else if (pick < 75) begin
                    md = MODE_MASK_CLR;
                end else if (pick < 85) begin
                    md = MODE_PRIO_RD;
                end else if (pick < 95) begin
                    md = MODE_MASK_RD;
                end else begin
                    md = ($urandom_range(0, 1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
                end
                send_word(md, idx, pick_val(), $urandom_range(0, 99) < 60);
            end
            drain();
            no_idle = 1'b0;
        end

        // let the block settle after the last word, then judge
        repeat (2 * SCAN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### interrupt_priority_controller_core.f
+incdir+rtl
rtl/ipc_pkg.sv
rtl/ipc_regs.sv
rtl/ipc_seq.sv
rtl/interrupt_priority_controller_core.sv
sim/interrupt_priority_controller_core_checker.sv
sim/tb_interrupt_priority_controller_core.sv
